@@ rtl/saw_pkg.sv @@
// Package for the strided array address walker.
// Shared sizes, register indexes, state encodings and control structs.
// No dependencies.
package saw_pkg;

    localparam int DIM_REGS        = 3;
    localparam int ELEM_W          = 13;
    localparam int ELEM_MAX        = 4096;
    localparam int RANK_W          = 2;
    localparam int STRIDE_W        = 32;
    localparam int ADDR_W          = 64;
    localparam int POFF_W          = 60;
    localparam int TOTAL_W         = 48;
    localparam int BCNT_W          = 12;
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DATA_W      = 32;
    localparam int MAX_RANK_DEF    = 3;
    localparam int EXTENT_BITS_DEF = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ELEM_BYTES = 3'd0,
        REG_RANK       = 3'd1,
        REG_EXTENT_0   = 3'd2,
        REG_EXTENT_1   = 3'd3,
        REG_EXTENT_2   = 3'd4,
        REG_STRIDE_0   = 3'd5,
        REG_STRIDE_1   = 3'd6,
        REG_STRIDE_2   = 3'd7
    } cfg_reg_t;

    typedef enum logic [1:0] {
        DV_IDLE,
        DV_MUL1,
        DV_MUL2
    } derive_state_t;

    typedef enum logic {
        WK_IDLE,
        WK_RUN
    } walk_state_t;

    typedef struct packed {
        logic start;
        logic advance;
        logic load_out;
        logic active;
    } walk_cmd_t;

    typedef struct packed {
        logic empty;
        logic final_byte;
    } walk_status_t;

endpackage

@@ rtl/saw_channels.sv @@
// Valid/ready channel interfaces for the address walker.
// Depends on saw_pkg for payload widths.
interface saw_in_if;
    logic                        valid;
    logic                        ready;
    logic                        start_req;
    logic [saw_pkg::ADDR_W-1:0]  base_address;

    modport source (output valid, output start_req, output base_address, input ready);
    modport sink   (input valid, input start_req, input base_address, output ready);
endinterface

interface saw_out_if;
    logic                        valid;
    logic                        ready;
    logic                        active;
    logic [saw_pkg::ADDR_W-1:0]  byte_address;
    logic [saw_pkg::POFF_W-1:0]  packed_offset;
    logic                        last_byte;
    logic                        contiguous;
    logic [saw_pkg::TOTAL_W-1:0] element_total;

    modport source (output valid, output active, output byte_address, output packed_offset,
                    output last_byte, output contiguous, output element_total, input ready);
    modport sink   (input valid, input active, input byte_address, input packed_offset,
                    input last_byte, input contiguous, input element_total, output ready);
endinterface

@@ rtl/saw_cfg.sv @@
// Configuration registers and derived values (element count, packed flag).
// Derived values are recomputed after each write; busy meanwhile.
// Depends on saw_pkg.
module saw_cfg #(
    parameter int MAX_RANK    = saw_pkg::MAX_RANK_DEF,
    parameter int EXTENT_BITS = saw_pkg::EXTENT_BITS_DEF
) (
    input  logic                                                   clk,
    input  logic                                                   rst_n,
    input  logic                                                   cfg_we,
    input  logic [saw_pkg::CFG_IDX_W-1:0]                          cfg_index,
    input  logic [saw_pkg::CFG_DATA_W-1:0]                         cfg_data,
    output logic [saw_pkg::ELEM_W-1:0]                             eff_elem,
    output logic [saw_pkg::RANK_W-1:0]                             eff_rank,
    output logic [saw_pkg::DIM_REGS-1:0][EXTENT_BITS-1:0]          extent,
    output logic [saw_pkg::DIM_REGS-1:0][saw_pkg::STRIDE_W-1:0]    stride,
    output logic                                                   busy,
    output logic                                                   contiguous,
    output logic [saw_pkg::TOTAL_W-1:0]                            element_total
);
    import saw_pkg::*;

    localparam int NDIM   = (MAX_RANK < DIM_REGS) ? MAX_RANK : DIM_REGS;
    localparam int E01_W  = 2 * EXTENT_BITS;
    localparam int SM1_W  = ELEM_W + EXTENT_BITS;
    localparam int SM2_W  = ELEM_W + 2 * EXTENT_BITS;

    logic [ELEM_W-1:0]                      elem_reg;
    logic [RANK_W-1:0]                      rank_reg;
    logic [DIM_REGS-1:0][EXTENT_BITS-1:0]   extent_reg;
    logic [DIM_REGS-1:0][STRIDE_W-1:0]      stride_reg;
    derive_state_t                          dv_state_reg, dv_state_next;

    logic [E01_W-1:0]                       e01_reg;
    logic [SM1_W-1:0]                       sm1_reg;
    logic [TOTAL_W-1:0]                     total_reg;
    logic                                   contig_reg;

    logic [E01_W-1:0]                       e01_full;
    logic [SM1_W-1:0]                       sm1_full;
    logic [TOTAL_W-1:0]                     tot3;
    logic [SM2_W-1:0]                       sm2_full;
    logic [TOTAL_W-1:0]                     total_sel;
    logic                                   contig_calc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            elem_reg   <= ELEM_W'(1);
            rank_reg   <= '0;
            for (int i = 0; i < DIM_REGS; i++)
            begin
                extent_reg[i] <= EXTENT_BITS'(1);
                stride_reg[i] <= STRIDE_W'(1);
            end
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_ELEM_BYTES: elem_reg      <= cfg_data[ELEM_W-1:0];
                REG_RANK:       rank_reg      <= cfg_data[RANK_W-1:0];
                REG_EXTENT_0:   extent_reg[0] <= cfg_data[EXTENT_BITS-1:0];
                REG_EXTENT_1:   extent_reg[1] <= cfg_data[EXTENT_BITS-1:0];
                REG_EXTENT_2:   extent_reg[2] <= cfg_data[EXTENT_BITS-1:0];
                REG_STRIDE_0:   stride_reg[0] <= cfg_data[STRIDE_W-1:0];
                REG_STRIDE_1:   stride_reg[1] <= cfg_data[STRIDE_W-1:0];
                REG_STRIDE_2:   stride_reg[2] <= cfg_data[STRIDE_W-1:0];
                default:        ;
            endcase
        end
    end

    assign eff_elem = (elem_reg > ELEM_W'(ELEM_MAX)) ? ELEM_W'(ELEM_MAX) : elem_reg;
    assign eff_rank = (rank_reg > RANK_W'(NDIM)) ? RANK_W'(NDIM) : rank_reg;
    assign extent   = extent_reg;
    assign stride   = stride_reg;

    // Recompute sequence; restarted by every write (reset also runs it once)
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dv_state_reg <= DV_MUL1;
        else
            dv_state_reg <= dv_state_next;
    end

    always_comb
    begin
        dv_state_next = dv_state_reg;
        case (dv_state_reg)
            DV_MUL1: dv_state_next = DV_MUL2;
            DV_MUL2: dv_state_next = DV_IDLE;
            DV_IDLE: dv_state_next = DV_IDLE;
            default: dv_state_next = DV_IDLE;
        endcase
        if (cfg_we)
            dv_state_next = DV_MUL1;
    end

    assign busy = (dv_state_reg != DV_IDLE);

    // First step: e0*e1 and elem*e0
    assign e01_full = E01_W'(extent_reg[0]) * E01_W'(extent_reg[1]);
    assign sm1_full = SM1_W'(eff_elem) * SM1_W'(extent_reg[0]);

    // Second step: e0*e1*e2 and elem*e0*e1 (wrapped)
    assign tot3     = TOTAL_W'(e01_reg) * TOTAL_W'(extent_reg[2]);
    assign sm2_full = SM2_W'(sm1_reg) * SM2_W'(extent_reg[1]);

    always_comb
    begin
        case (eff_rank)
            2'd0:    total_sel = TOTAL_W'(1);
            2'd1:    total_sel = TOTAL_W'(extent_reg[0]);
            2'd2:    total_sel = TOTAL_W'(e01_reg);
            default: total_sel = tot3;
        endcase
        contig_calc = 1'b1;
        if (eff_rank >= 2'd1 &&
            {{(ADDR_W-STRIDE_W){stride_reg[0][STRIDE_W-1]}}, stride_reg[0]} != ADDR_W'(eff_elem))
            contig_calc = 1'b0;
        if (eff_rank >= 2'd2 &&
            {{(ADDR_W-STRIDE_W){stride_reg[1][STRIDE_W-1]}}, stride_reg[1]} != ADDR_W'(sm1_reg))
            contig_calc = 1'b0;
        if (eff_rank >= 2'd3 &&
            {{(ADDR_W-STRIDE_W){stride_reg[2][STRIDE_W-1]}}, stride_reg[2]} != ADDR_W'(sm2_full))
            contig_calc = 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (dv_state_reg == DV_MUL1)
        begin
            e01_reg <= e01_full;
            sm1_reg <= sm1_full;
        end
        if (dv_state_reg == DV_MUL2)
        begin
            total_reg  <= total_sel;
            contig_reg <= contig_calc;
        end
    end

    assign contiguous    = contig_reg;
    assign element_total = total_reg;

endmodule

@@ rtl/saw_dp.sv @@
// Walk datapath: byte counter, per-dimension indexes and start addresses,
// packed position and the result register. Depends on saw_pkg.
module saw_dp #(
    parameter int MAX_RANK    = saw_pkg::MAX_RANK_DEF,
    parameter int EXTENT_BITS = saw_pkg::EXTENT_BITS_DEF
) (
    input  logic                                                   clk,
    input  logic                                                   rst_n,
    input  saw_pkg::walk_cmd_t                                     cmd,
    input  logic [saw_pkg::ADDR_W-1:0]                             base_address,
    input  logic [saw_pkg::ELEM_W-1:0]                             eff_elem,
    input  logic [saw_pkg::RANK_W-1:0]                             eff_rank,
    input  logic [saw_pkg::DIM_REGS-1:0][EXTENT_BITS-1:0]          extent,
    input  logic [saw_pkg::DIM_REGS-1:0][saw_pkg::STRIDE_W-1:0]    stride,
    input  logic                                                   cfg_contiguous,
    input  logic [saw_pkg::TOTAL_W-1:0]                            cfg_total,
    output saw_pkg::walk_status_t                                  status,
    output logic                                                   active,
    output logic [saw_pkg::ADDR_W-1:0]                             byte_address,
    output logic [saw_pkg::POFF_W-1:0]                             packed_offset,
    output logic                                                   last_byte,
    output logic                                                   contiguous,
    output logic [saw_pkg::TOTAL_W-1:0]                            element_total
);
    import saw_pkg::*;

    localparam int NDIM = (MAX_RANK < DIM_REGS) ? MAX_RANK : DIM_REGS;
    localparam int IW   = EXTENT_BITS + 1;

    logic [BCNT_W-1:0]                   bcnt_reg, bcnt_next;
    logic [NDIM-1:0][EXTENT_BITS-1:0]    idx_reg, idx_next;
    logic [NDIM-1:0][ADDR_W-1:0]         dstart_reg, dstart_next;
    logic [ADDR_W-1:0]                   eaddr_reg, eaddr_next;
    logic [POFF_W-1:0]                   ppos_reg, ppos_next;

    logic                                active_reg;
    logic [ADDR_W-1:0]                   addr_reg;
    logic [POFF_W-1:0]                   poff_reg;
    logic                                last_reg;
    logic                                contig_reg;
    logic [TOTAL_W-1:0]                  total_reg;

    logic [ELEM_W-1:0]                   bc_inc;
    logic                                bytes_more;
    logic [NDIM-1:0]                     idx_more;
    logic [NDIM-1:0]                     hit;
    logic [NDIM-1:0]                     above;
    logic [NDIM-1:0][ADDR_W-1:0]         dsum;
    logic [ADDR_W-1:0]                   new_ea;
    logic                                any_more;
    logic                                ext_zero;
    logic [ADDR_W-1:0]                   cur_addr;

    assign bc_inc     = ELEM_W'(bcnt_reg) + ELEM_W'(1);
    assign bytes_more = (bc_inc < eff_elem);
    assign cur_addr   = eaddr_reg + ADDR_W'(bcnt_reg);

    // Carry search: lowest dimension that still has room takes the step
    always_comb
    begin
        logic lower;
        logic upper;
        lower    = 1'b0;
        ext_zero = 1'b0;
        new_ea   = '0;
        for (int d = 0; d < NDIM; d++)
        begin
            idx_more[d] = (RANK_W'(d) < eff_rank) &&
                          ((IW'(idx_reg[d]) + IW'(1)) < IW'(extent[d]));
            hit[d]      = idx_more[d] & ~lower;
            lower       = lower | idx_more[d];
            dsum[d]     = dstart_reg[d] +
                          {{(ADDR_W-STRIDE_W){stride[d][STRIDE_W-1]}}, stride[d]};
            if (hit[d])
                new_ea = dsum[d];
            if ((RANK_W'(d) < eff_rank) && (extent[d] == '0))
                ext_zero = 1'b1;
        end
        any_more = lower;
        upper    = 1'b0;
        for (int d = NDIM - 1; d >= 0; d--)
        begin
            above[d] = upper;
            upper    = upper | hit[d];
        end
    end

    assign status.final_byte = !bytes_more && !any_more;
    assign status.empty      = (eff_elem == '0) || ext_zero;

    always_comb
    begin
        bcnt_next   = bcnt_reg;
        idx_next    = idx_reg;
        dstart_next = dstart_reg;
        eaddr_next  = eaddr_reg;
        ppos_next   = ppos_reg;
        if (cmd.start)
        begin
            bcnt_next  = '0;
            eaddr_next = base_address;
            ppos_next  = '0;
            for (int d = 0; d < NDIM; d++)
            begin
                idx_next[d]    = '0;
                dstart_next[d] = base_address;
            end
        end
        else if (cmd.advance)
        begin
            ppos_next = ppos_reg + POFF_W'(1);
            if (bytes_more)
                bcnt_next = bc_inc[BCNT_W-1:0];
            else
            begin
                bcnt_next = '0;
                for (int d = 0; d < NDIM; d++)
                begin
                    if (hit[d])
                    begin
                        idx_next[d]    = idx_reg[d] + EXTENT_BITS'(1);
                        dstart_next[d] = dsum[d];
                    end
                    else if (above[d])
                    begin
                        idx_next[d]    = '0;
                        dstart_next[d] = new_ea;
                    end
                end
                if (any_more)
                    eaddr_next = new_ea;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bcnt_reg <= '0;
            idx_reg  <= '0;
            ppos_reg <= '0;
        end
        else
        begin
            bcnt_reg <= bcnt_next;
            idx_reg  <= idx_next;
            ppos_reg <= ppos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dstart_reg <= dstart_next;
        eaddr_reg  <= eaddr_next;
        if (cmd.load_out)
        begin
            active_reg <= cmd.active;
            addr_reg   <= cmd.active ? cur_addr : '0;
            poff_reg   <= cmd.active ? ppos_reg : '0;
            last_reg   <= cmd.active & status.final_byte;
            contig_reg <= cfg_contiguous;
            total_reg  <= cfg_total;
        end
    end

    assign active        = active_reg;
    assign byte_address  = addr_reg;
    assign packed_offset = poff_reg;
    assign last_byte     = last_reg;
    assign contiguous    = contig_reg;
    assign element_total = total_reg;

endmodule

@@ rtl/saw_ctrl.sv @@
// Walk controller: walk state, input/output handshakes, datapath commands.
// Depends on saw_pkg.
module saw_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  start_req,
    input  logic                  out_ready,
    input  logic                  cfg_busy,
    input  saw_pkg::walk_status_t status,
    output logic                  in_ready,
    output logic                  out_valid,
    output saw_pkg::walk_cmd_t    cmd
);
    import saw_pkg::*;

    walk_state_t state_reg, state_next;
    logic        out_valid_reg, out_valid_next;
    logic        accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= WK_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        in_ready       = (!out_valid_reg || out_ready) && !cfg_busy;
        accept         = in_valid && in_ready;
        cmd            = '0;
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        if (accept)
        begin
            out_valid_next = 1'b1;
            cmd.load_out   = 1'b1;
            if (start_req)
            begin
                cmd.start  = 1'b1;
                state_next = status.empty ? WK_IDLE : WK_RUN;
            end
            else
            begin
                case (state_reg)
                    WK_RUN:
                    begin
                        cmd.advance = 1'b1;
                        cmd.active  = 1'b1;
                        if (status.final_byte)
                            state_next = WK_IDLE;
                    end
                    WK_IDLE: ;
                    default: state_next = WK_IDLE;
                endcase
            end
        end
    end

    assign out_valid = out_valid_reg;

endmodule

@@ rtl/strided_array_address_walker.sv @@
// Top level of the strided array address walker.
// Depends on saw_pkg, saw_channels, saw_cfg, saw_dp, saw_ctrl.
//
//   port       dir    payload                                     accept
//   walk_in    sink   start_req, base_address                     valid & ready
//   walk_out   source active, byte_address, packed_offset,        valid & ready
//                     last_byte, contiguous, element_total
//   cfg_*      write  cfg_index, cfg_data                         cfg_we
//
// One item per cycle while ready is high (see below); each item gives its
// result in the next cycle from the output register, and a new item is
// taken while that result is taken. After every register write ready drops
// while the element count and packed flag are recomputed through two
// multiply steps. The same recompute runs once out of reset, so ready stays
// low after rst_n rises until it is done; a stalled output holds input off.
module strided_array_address_walker #(
    parameter int MAX_RANK    = saw_pkg::MAX_RANK_DEF,
    parameter int EXTENT_BITS = saw_pkg::EXTENT_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    saw_in_if.sink                          walk_in,
    saw_out_if.source                       walk_out,
    input  logic                            cfg_we,
    input  logic [saw_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [saw_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import saw_pkg::*;

    logic [ELEM_W-1:0]                      eff_elem;
    logic [RANK_W-1:0]                      eff_rank;
    logic [DIM_REGS-1:0][EXTENT_BITS-1:0]   extent;
    logic [DIM_REGS-1:0][STRIDE_W-1:0]      stride;
    logic                                   cfg_busy;
    logic                                   cfg_contiguous;
    logic [TOTAL_W-1:0]                     cfg_total;
    walk_cmd_t                              cmd;
    walk_status_t                           status;

    saw_cfg #(
        .MAX_RANK    (MAX_RANK),
        .EXTENT_BITS (EXTENT_BITS)
    ) u_cfg (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .eff_elem      (eff_elem),
        .eff_rank      (eff_rank),
        .extent        (extent),
        .stride        (stride),
        .busy          (cfg_busy),
        .contiguous    (cfg_contiguous),
        .element_total (cfg_total)
    );

    saw_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (walk_in.valid),
        .start_req (walk_in.start_req),
        .out_ready (walk_out.ready),
        .cfg_busy  (cfg_busy),
        .status    (status),
        .in_ready  (walk_in.ready),
        .out_valid (walk_out.valid),
        .cmd       (cmd)
    );

    saw_dp #(
        .MAX_RANK    (MAX_RANK),
        .EXTENT_BITS (EXTENT_BITS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .base_address   (walk_in.base_address),
        .eff_elem       (eff_elem),
        .eff_rank       (eff_rank),
        .extent         (extent),
        .stride         (stride),
        .cfg_contiguous (cfg_contiguous),
        .cfg_total      (cfg_total),
        .status         (status),
        .active         (walk_out.active),
        .byte_address   (walk_out.byte_address),
        .packed_offset  (walk_out.packed_offset),
        .last_byte      (walk_out.last_byte),
        .contiguous     (walk_out.contiguous),
        .element_total  (walk_out.element_total)
    );

endmodule

@@ dv/tb_top.sv @@
// Self-checking bench for strided_array_address_walker: random and directed walks,
// with a built-in address predictor and random stalls on both channels.
// Depends on rtl/saw_pkg.sv, rtl/saw_channels.sv and the walker RTL.
module tb_top;
    import saw_pkg::*;

    typedef struct packed {
        logic              start;
        logic [ADDR_W-1:0] base;
    } walk_request_t;

    typedef struct packed {
        logic               active;
        logic [ADDR_W-1:0]  byte_address;
        logic [POFF_W-1:0]  packed_offset;
        logic               last_byte;
        logic               contiguous;
        logic [TOTAL_W-1:0] element_total;
    } walk_result_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    saw_in_if  walk_in();
    saw_out_if walk_out();

    strided_array_address_walker dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .walk_in   (walk_in),
        .walk_out  (walk_out),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // register shadow
    logic [ELEM_W-1:0]          elem_cfg;
    logic [RANK_W-1:0]          rank_cfg;
    logic [EXTENT_BITS_DEF-1:0] extent_cfg [DIM_REGS];
    logic [STRIDE_W-1:0]        stride_cfg [DIM_REGS];

    // walk position
    logic                       walking_now;
    logic [BCNT_W-1:0]          byte_idx;
    logic [EXTENT_BITS_DEF-1:0] dim_pos [DIM_REGS];
    logic [ADDR_W-1:0]          elem_addr;
    logic [ADDR_W-1:0]          dim_base [DIM_REGS];
    logic [POFF_W-1:0]          packed_pos;

    walk_request_t walk_requests [$];
    walk_result_t  pending_results [$];
    walk_request_t next_request;
    walk_result_t  seen_result;
    walk_result_t  due_result;
    int unsigned   items_queued;
    int unsigned   mismatch_count;
    int unsigned   send_gap;
    int unsigned   stall_left;
    logic          steady_run;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic logic [63:0] elem_size();
        return (elem_cfg > ELEM_MAX) ? 64'(ELEM_MAX) : 64'(elem_cfg);
    endfunction

    function automatic logic [63:0] stride64(input int d);
        return {{32{stride_cfg[d][31]}}, stride_cfg[d]};
    endfunction

    function automatic walk_result_t next_walk_result(input logic start,
                                                      input logic [ADDR_W-1:0] base);
        walk_result_t res;
        logic [63:0]  sm;
        logic [63:0]  prod;
        logic         packed_ok;
        logic         empty;
        logic         stepped;
        int           k;
        res = '0;
        k = rank_cfg;
        if (start)
        begin
            elem_addr = base;
            byte_idx = '0;
            packed_pos = '0;
            empty = (elem_size() == 0);
            for (int d = 0; d < DIM_REGS; d++)
            begin
                dim_pos[d] = '0;
                dim_base[d] = base;
                if (d < k && extent_cfg[d] == 0)
                    empty = 1'b1;
            end
            walking_now = !empty;
        end
        else if (walking_now)
        begin
            res.active = 1'b1;
            res.byte_address = elem_addr + byte_idx;
            res.packed_offset = packed_pos;
            res.last_byte = (byte_idx + 1 >= elem_size());
            for (int d = 0; d < k; d++)
                if (dim_pos[d] + 1 < extent_cfg[d])
                    res.last_byte = 1'b0;
            packed_pos = packed_pos + 1'b1;
            if (byte_idx + 1 < elem_size())
                byte_idx = byte_idx + 1'b1;
            else
            begin
                // element done: bump the lowest dimension that still has room
                byte_idx = '0;
                stepped = 1'b0;
                for (int d = 0; d < k; d++)
                begin
                    if (!stepped && dim_pos[d] + 1 < extent_cfg[d])
                    begin
                        stepped = 1'b1;
                        dim_pos[d] = dim_pos[d] + 1'b1;
                        dim_base[d] = dim_base[d] + stride64(d);
                        for (int e = 0; e < d; e++)
                        begin
                            dim_pos[e] = '0;
                            dim_base[e] = dim_base[d];
                        end
                        elem_addr = dim_base[d];
                    end
                end
                if (!stepped)
                    walking_now = 1'b0;
            end
            if (res.last_byte)
                walking_now = 1'b0;
        end
        sm = elem_size();
        prod = 64'd1;
        packed_ok = 1'b1;
        for (int d = 0; d < k; d++)
        begin
            if (sm != stride64(d))
                packed_ok = 1'b0;
            sm = sm * extent_cfg[d];
            prod = prod * extent_cfg[d];
        end
        res.contiguous = packed_ok;
        res.element_total = prod[TOTAL_W-1:0];
        return res;
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (steady_run || r < 70)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [ADDR_W-1:0] pick_base();
        int unsigned r;
        r = $urandom_range(0, 3);
        if (r == 1)
            return 64'($urandom_range(0, 255));
        if (r == 2)
            return ~64'($urandom_range(0, 255));
        return {$urandom, $urandom};
    endfunction

    function automatic logic [31:0] pick_extent();
        int unsigned r;
        r = $urandom_range(0, 15);
        if (r == 0)
            return 32'd0;
        if (r == 1)
            return 32'd65535;
        if (r == 2)
            return $urandom_range(0, 65535);
        return $urandom_range(1, 4);
    endfunction

    function automatic logic [31:0] pick_stride(input logic [31:0] packed_stride);
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r < 5)
            return packed_stride;
        if (r < 8)
            return 32'($urandom_range(0, 32)) - 32'd16;
        if (r == 8)
            return ($urandom_range(0, 1) == 0) ? 32'h8000_0000 : 32'h7FFF_FFFF;
        return $urandom;
    endfunction

    task automatic flag_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
        mismatch_count++;
        $display("%0t: %s mismatch, got %h want %h", $realtime, what, got, want);
    endtask

    task automatic push_item(input logic start, input logic [ADDR_W-1:0] base);
        walk_requests.push_back('{start: start, base: base});
        items_queued++;
    endtask

    task automatic wait_drained();
        while (walk_requests.size() != 0 || walk_in.valid || pending_results.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [31:0] data);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        case (idx)
            REG_ELEM_BYTES: elem_cfg = data[ELEM_W-1:0];
            REG_RANK:       rank_cfg = data[RANK_W-1:0];
            REG_EXTENT_0:   extent_cfg[0] = data[EXTENT_BITS_DEF-1:0];
            REG_EXTENT_1:   extent_cfg[1] = data[EXTENT_BITS_DEF-1:0];
            REG_EXTENT_2:   extent_cfg[2] = data[EXTENT_BITS_DEF-1:0];
            REG_STRIDE_0:   stride_cfg[0] = data;
            REG_STRIDE_1:   stride_cfg[1] = data;
            REG_STRIDE_2:   stride_cfg[2] = data;
            default:        ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic shuffle_config();
        logic [63:0] sm;
        int unsigned r;
        if ($urandom_range(0, 2) == 0)
        begin
            r = $urandom_range(0, 19);
            write_reg(REG_ELEM_BYTES, (r == 0) ? 32'd0 :
                                      (r == 1) ? 32'd4096 :
                                      (r == 2) ? $urandom_range(4097, 8191) :
                                      (r == 3) ? $urandom : $urandom_range(1, 6));
        end
        if ($urandom_range(0, 2) == 0)
            write_reg(REG_RANK, $urandom_range(0, 3));
        for (int d = 0; d < DIM_REGS; d++)
            if ($urandom_range(0, 2) == 0)
                write_reg(cfg_reg_t'(REG_EXTENT_0 + d), pick_extent());
        // strides last so a packed choice sees the final extents
        sm = elem_size();
        for (int d = 0; d < DIM_REGS; d++)
        begin
            if ($urandom_range(0, 2) == 0)
                write_reg(cfg_reg_t'(REG_STRIDE_0 + d), pick_stride(sm[31:0]));
            sm = sm * extent_cfg[d];
        end
    endtask

    // sender
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            walk_in.valid <= 1'b0;
            send_gap = 0;
        end
        else
        begin
            if (walk_in.valid && walk_in.ready)
                pending_results.push_back(next_walk_result(walk_in.start_req,
                                                           walk_in.base_address));
            if (!walk_in.valid || walk_in.ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    walk_in.valid <= 1'b0;
                end
                else if (walk_requests.size() > 0)
                begin
                    next_request = walk_requests.pop_front();
                    walk_in.valid <= 1'b1;
                    walk_in.start_req <= next_request.start;
                    walk_in.base_address <= next_request.base;
                    send_gap = pick_gap();
                end
                else
                    walk_in.valid <= 1'b0;
            end
        end
    end

    // receiver and checker
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            walk_out.ready <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (walk_out.valid && walk_out.ready)
            begin
                seen_result.active = walk_out.active;
                seen_result.byte_address = walk_out.byte_address;
                seen_result.packed_offset = walk_out.packed_offset;
                seen_result.last_byte = walk_out.last_byte;
                seen_result.contiguous = walk_out.contiguous;
                seen_result.element_total = walk_out.element_total;
                if (pending_results.size() == 0)
                    flag_mismatch("unexpected item", seen_result.byte_address, '0);
                else
                begin
                    due_result = pending_results.pop_front();
                    if (seen_result.active != due_result.active)
                        flag_mismatch("active", seen_result.active, due_result.active);
                    if (seen_result.byte_address != due_result.byte_address)
                        flag_mismatch("byte_address", seen_result.byte_address,
                                      due_result.byte_address);
                    if (seen_result.packed_offset != due_result.packed_offset)
                        flag_mismatch("packed_offset", seen_result.packed_offset,
                                      due_result.packed_offset);
                    if (seen_result.last_byte != due_result.last_byte)
                        flag_mismatch("last_byte", seen_result.last_byte,
                                      due_result.last_byte);
                    if (seen_result.contiguous != due_result.contiguous)
                        flag_mismatch("contiguous", seen_result.contiguous,
                                      due_result.contiguous);
                    if (seen_result.element_total != due_result.element_total)
                        flag_mismatch("element_total", seen_result.element_total,
                                      due_result.element_total);
                end
            end
            if (stall_left > 0)
            begin
                stall_left--;
                walk_out.ready <= 1'b0;
            end
            else
            begin
                walk_out.ready <= 1'b1;
                stall_left = pick_gap();
            end
        end
    end

    initial
    begin
        logic [63:0] walk_len;
        int unsigned n;
        clk = 1'b0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_ELEM_BYTES;
        cfg_data = '0;
        walk_in.valid = 1'b0;
        walk_in.start_req = 1'b0;
        walk_in.base_address = '0;
        walk_out.ready = 1'b0;
        steady_run = 1'b0;
        items_queued = 0;
        mismatch_count = 0;
        elem_cfg = 1;
        rank_cfg = 0;
        walking_now = 1'b0;
        byte_idx = '0;
        elem_addr = '0;
        packed_pos = '0;
        for (int d = 0; d < DIM_REGS; d++)
        begin
            extent_cfg[d] = 1;
            stride_cfg[d] = 1;
            dim_pos[d] = '0;
            dim_base[d] = '0;
        end
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // scalar walk on reset registers, plus an advance with nothing running
        push_item(1'b0, pick_base());
        push_item(1'b1, '0);
        push_item(1'b0, pick_base());
        push_item(1'b0, pick_base());
        wait_drained();

        // packed 3-D walk that wraps past the top of the address space
        write_reg(REG_ELEM_BYTES, 32'd3);
        write_reg(REG_RANK, 32'd3);
        write_reg(REG_EXTENT_0, 32'd2);
        write_reg(REG_EXTENT_1, 32'd2);
        write_reg(REG_EXTENT_2, 32'd1);
        write_reg(REG_STRIDE_0, 32'd3);
        write_reg(REG_STRIDE_1, 32'd6);
        write_reg(REG_STRIDE_2, 32'd12);
        push_item(1'b1, 64'hFFFF_FFFF_FFFF_FFF8);
        repeat (13) push_item(1'b0, pick_base());
        wait_drained();

        // largest element and extents, extreme strides, restart mid-walk
        write_reg(REG_ELEM_BYTES, 32'd4096);
        write_reg(REG_EXTENT_0, 32'd65535);
        write_reg(REG_EXTENT_1, 32'd65535);
        write_reg(REG_EXTENT_2, 32'd65535);
        write_reg(REG_STRIDE_0, 32'h8000_0000);
        write_reg(REG_STRIDE_1, 32'h7FFF_FFFF);
        write_reg(REG_STRIDE_2, 32'hFFFF_FFFF);
        push_item(1'b1, 64'hFFFF_FFFF_FFFF_FFFF);
        push_item(1'b0, '0);
        push_item(1'b0, '0);
        push_item(1'b1, '0);
        push_item(1'b0, 64'hFFFF_FFFF_FFFF_FFFF);
        wait_drained();

        // oversized element with a zero extent: empty walk
        write_reg(REG_ELEM_BYTES, 32'd8191);
        write_reg(REG_RANK, 32'd2);
        write_reg(REG_EXTENT_1, 32'd0);
        push_item(1'b1, 64'h5555_5555_5555_5555);
        push_item(1'b0, 64'hAAAA_AAAA_AAAA_AAAA);
        wait_drained();

        // zero-byte element: empty walk
        write_reg(REG_ELEM_BYTES, 32'd0);
        write_reg(REG_EXTENT_1, 32'd1);
        push_item(1'b1, pick_base());
        push_item(1'b0, pick_base());

        n = items_queued;
        while (items_queued < n + 1300)
        begin
            wait_drained();
            steady_run = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 3) != 0)
                shuffle_config();
            // keep stepping a walk left open across the register update
            if ($urandom_range(0, 4) == 0)
                repeat ($urandom_range(1, 6)) push_item(1'b0, pick_base());
            repeat ($urandom_range(1, 3))
            begin
                walk_len = elem_size();
                for (int d = 0; d < rank_cfg; d++)
                    walk_len = walk_len * extent_cfg[d];
                push_item(1'b1, pick_base());
                if (walk_len <= 48 && $urandom_range(0, 5) != 0)
                    repeat (walk_len + $urandom_range(0, 2)) push_item(1'b0, pick_base());
                else
                    repeat ($urandom_range(1, 20)) push_item(1'b0, pick_base());
                if ($urandom_range(0, 9) == 0)
                    push_item(1'b1, pick_base());
            end
        end

        wait_drained();
        repeat (20) @(posedge clk);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        #4000000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
